// ----- hw/rtl/stac_pkg.sv -----
package stac_pkg;

   // field widths of the term words
   localparam int COEF_W = 32;
   localparam int EXPO_W = 16;

   // request kinds
   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // result status codes
   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_COMBINED  = 3'd1,
      ST_CANCELLED = 3'd2,
      ST_ZERO      = 3'd3,
      ST_FULL      = 3'd4,
      ST_TERM      = 3'd5,
      ST_EMPTY     = 3'd6
   } stac_status_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_ADD_CMP,
      S_ADD_UPD,
      S_READ
   } stac_state_type;

   // request word
   typedef struct packed {
      logic [1:0]               kind;
      logic signed [COEF_W-1:0] term_coef;
      logic signed [EXPO_W-1:0] term_expo;
   } stac_req_type;

   // result word
   typedef struct packed {
      logic signed [COEF_W-1:0] out_coef;
      logic signed [EXPO_W-1:0] out_expo;
      stac_status_type          status;
      logic                     last;
   } stac_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic clear;
      logic cmp;
      logic upd;
      logic rd_emit;
      logic emit_empty;
   } stac_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic count_zero;
      logic rd_last;
      logic rsp_free;
   } stac_stat_type;

endpackage

// ----- hw/rtl/stac_ctrl.sv -----
module stac_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_kind,
   output logic                   req_stall,
   input  stac_pkg::stac_stat_type stat,
   output stac_pkg::stac_cmd_type  cmd
);

   stac_pkg::stac_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stac_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         stac_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_kind)
                  stac_pkg::KIND_ADD:   state_in = stac_pkg::S_ADD_CMP;
                  stac_pkg::KIND_READ:  state_in = stac_pkg::S_READ;
                  stac_pkg::KIND_CLEAR: cmd.clear = 1'b1;
                  default:              state_in = stac_pkg::S_IDLE;
               endcase
            end
         end
         stac_pkg::S_ADD_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = stac_pkg::S_ADD_UPD;
         end
         stac_pkg::S_ADD_UPD: begin
            if (stat.rsp_free) begin
               cmd.upd  = 1'b1;
               state_in = stac_pkg::S_IDLE;
            end
         end
         stac_pkg::S_READ: begin
            if (stat.rsp_free) begin
               if (stat.count_zero) begin
                  cmd.emit_empty = 1'b1;
                  state_in       = stac_pkg::S_IDLE;
               end else begin
                  cmd.rd_emit = 1'b1;
                  if (stat.rd_last) begin
                     state_in = stac_pkg::S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = stac_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/stac_datapath.sv -----
module stac_datapath #(
   parameter int MAX_TERMS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  stac_pkg::stac_req_type req_data,
   input  stac_pkg::stac_cmd_type cmd,
   output stac_pkg::stac_stat_type stat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output stac_pkg::stac_rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam int CW    = stac_pkg::COEF_W;
   localparam int EW    = stac_pkg::EXPO_W;

   // term cells
   logic signed [CW-1:0] coef_ff [MAX_TERMS];
   logic signed [CW-1:0] coef_in [MAX_TERMS];
   logic signed [EW-1:0] expo_ff [MAX_TERMS];
   logic signed [EW-1:0] expo_in [MAX_TERMS];

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in, rd_cnt_inc;
   stac_pkg::stac_req_type req_ff;

   // compare stage results
   logic [MAX_TERMS-1:0] gt_ff, gt_in;
   logic [MAX_TERMS-1:0] eq_ff, eq_in;
   logic signed [CW-1:0] mcoef_ff, mcoef_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   stac_pkg::stac_rsp_type rsp_ff, rsp_in;

   logic                 hit, full, coef_zero, sum_zero;
   logic [CW:0]          sum_wide;
   logic signed [CW-1:0] sum_sat;
   logic                 do_del, do_comb, do_ins;

   // per cell exponent compare and matching coefficient pick
   always_comb begin
      mcoef_in = '0;
      for (int j = 0; j < MAX_TERMS; j++) begin
         gt_in[j] = (CNT_W'(j) < count_ff) && (expo_ff[j] > req_ff.term_expo);
         eq_in[j] = (CNT_W'(j) < count_ff) && (expo_ff[j] == req_ff.term_expo);
         mcoef_in = mcoef_in | (eq_in[j] ? coef_ff[j] : '0);
      end
   end

   // saturating sum with the matching term
   always_comb begin
      sum_wide = {mcoef_ff[CW-1], mcoef_ff} + {req_ff.term_coef[CW-1], req_ff.term_coef};
      if (sum_wide[CW] != sum_wide[CW-1]) begin
         sum_sat = sum_wide[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[CW-1:0];
      end
   end

   assign hit       = |eq_ff;
   assign full      = (count_ff == CNT_W'(MAX_TERMS));
   assign coef_zero = (req_ff.term_coef == '0);
   assign sum_zero  = (sum_sat == '0);
   assign do_del    = cmd.upd && !coef_zero && hit && sum_zero;
   assign do_comb   = cmd.upd && !coef_zero && hit && !sum_zero;
   assign do_ins    = cmd.upd && !coef_zero && !hit && !full;

   // cell next values: read rotate, delete shift, insert shift, combine
   for (genvar j = 0; j < MAX_TERMS; j++) begin : g_cell
      always_comb begin
         coef_in[j] = coef_ff[j];
         expo_in[j] = expo_ff[j];
         if (cmd.rd_emit) begin
            if (count_ff == CNT_W'(j + 1)) begin
               coef_in[j] = coef_ff[0];
               expo_in[j] = expo_ff[0];
            end else begin
               if (j < MAX_TERMS - 1) begin
                  coef_in[j] = coef_ff[(j + 1) % MAX_TERMS];
                  expo_in[j] = expo_ff[(j + 1) % MAX_TERMS];
               end
            end
         end else if (do_del) begin
            if (!gt_ff[j] && (j < MAX_TERMS - 1)) begin
               coef_in[j] = coef_ff[(j + 1) % MAX_TERMS];
               expo_in[j] = expo_ff[(j + 1) % MAX_TERMS];
            end
         end else if (do_comb) begin
            if (eq_ff[j]) begin
               coef_in[j] = sum_sat;
            end
         end else if (do_ins) begin
            if (!gt_ff[j]) begin
               if ((j == 0) || gt_ff[(j + MAX_TERMS - 1) % MAX_TERMS]) begin
                  coef_in[j] = req_ff.term_coef;
                  expo_in[j] = req_ff.term_expo;
               end else begin
                  coef_in[j] = coef_ff[(j + MAX_TERMS - 1) % MAX_TERMS];
                  expo_in[j] = expo_ff[(j + MAX_TERMS - 1) % MAX_TERMS];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         coef_ff[j] <= coef_in[j];
         expo_ff[j] <= expo_in[j];
      end
   end

   // term count and read counter
   assign rd_cnt_inc = rd_cnt_ff + CNT_W'(1);

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (do_del) begin
         count_in = count_ff - CNT_W'(1);
      end else if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end
      rd_cnt_in = rd_cnt_ff;
      if (cmd.capture) begin
         rd_cnt_in = '0;
      end else if (cmd.rd_emit) begin
         rd_cnt_in = rd_cnt_inc;
      end
   end

   // result word build
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (cmd.upd) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.last  = 1'b1;
         if (coef_zero) begin
            rsp_in.status = stac_pkg::ST_ZERO;
         end else if (hit && sum_zero) begin
            rsp_in.status = stac_pkg::ST_CANCELLED;
         end else if (hit) begin
            rsp_in.status   = stac_pkg::ST_COMBINED;
            rsp_in.out_coef = sum_sat;
            rsp_in.out_expo = req_ff.term_expo;
         end else if (full) begin
            rsp_in.status = stac_pkg::ST_FULL;
         end else begin
            rsp_in.status   = stac_pkg::ST_INSERTED;
            rsp_in.out_coef = req_ff.term_coef;
            rsp_in.out_expo = req_ff.term_expo;
         end
      end else if (cmd.rd_emit) begin
         rsp_valid_in    = 1'b1;
         rsp_in.out_coef = coef_ff[0];
         rsp_in.out_expo = expo_ff[0];
         rsp_in.status   = stac_pkg::ST_TERM;
         rsp_in.last     = (rd_cnt_inc == count_ff);
      end else if (cmd.emit_empty) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = '0;
         rsp_in.status = stac_pkg::ST_EMPTY;
         rsp_in.last   = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_cnt_ff <= rd_cnt_in;
      rsp_ff    <= rsp_in;
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.cmp) begin
         gt_ff    <= gt_in;
         eq_ff    <= eq_in;
         mcoef_ff <= mcoef_in;
      end
   end

   assign stat.count_zero = (count_ff == '0);
   assign stat.rd_last    = (rd_cnt_inc == count_ff);
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

// ----- hw/rtl/sorted_term_accumulator_core.sv -----
// Sparse polynomial accumulator: holds up to MAX_TERMS terms in descending
// exponent order in a chain of term cells. An add word passes through
// capture, a parallel exponent compare over all cells, then a saturating
// sum and shift of the cells, and gives one result word. A read word gives
// one result per stored term, one per cycle while the output is not stalled,
// by rotation of the cell chain through its head cell; an empty table gives
// one empty result. A clear word gives no result. Results wait in an output
// register, so a stalled result delays only the next emission.
module sorted_term_accumulator_core #(
   parameter int MAX_TERMS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  stac_pkg::stac_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output stac_pkg::stac_rsp_type rsp_data
);

   stac_pkg::stac_cmd_type  cmd;
   stac_pkg::stac_stat_type stat;

   // sequencer
   stac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // term cells and result register
   stac_datapath #(
      .MAX_TERMS (MAX_TERMS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hw/rtl/stac_checker.sv -----
module stac_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input stac_pkg::stac_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input stac_pkg::stac_rsp_type rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // status-only results carry no term
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == stac_pkg::ST_CANCELLED ||
                    rsp_data.status == stac_pkg::ST_ZERO ||
                    rsp_data.status == stac_pkg::ST_FULL ||
                    rsp_data.status == stac_pkg::ST_EMPTY)
      |-> rsp_data.out_coef == '0 && rsp_data.out_expo == '0)
      else $error("status-only result carries a term");

   // only term words can be non-final
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != stac_pkg::ST_TERM |-> rsp_data.last)
      else $error("single result without last");

   // stored terms are never zero
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == stac_pkg::ST_INSERTED ||
                    rsp_data.status == stac_pkg::ST_COMBINED ||
                    rsp_data.status == stac_pkg::ST_TERM)
      |-> rsp_data.out_coef != '0)
      else $error("zero coefficient in stored term");

   // add and read words keep the block busy on the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.kind == stac_pkg::KIND_ADD || req_data.kind == stac_pkg::KIND_READ)
      |=> req_stall)
      else $error("new word taken while busy");

endmodule

bind sorted_term_accumulator_core stac_checker u_stac_checker (.*);

// ----- test/sorted_term_accumulator_core_tb.sv -----
`timescale 1ns / 1ps

// scoreboard: keeps its own copy of the term table and the words still owed
class poly_scoreboard;
   localparam longint SUM_HI = 64'sd2147483647;
   localparam longint SUM_LO = -64'sd2147483648;

   int                     depth;
   logic signed [31:0]     coef_tbl[$];
   logic signed [15:0]     expo_tbl[$];
   stac_pkg::stac_rsp_type want_q[$];
   int                     bad_count;
   int                     request_count;
   int                     result_count;
   int                     peak_terms;
   int                     status_seen[8];

   function new(int max_terms);
      depth = max_terms;
   endfunction

   function void owe_word(logic signed [31:0] c, logic signed [15:0] e,
                          stac_pkg::stac_status_type st, logic last);
      stac_pkg::stac_rsp_type w;
      w.out_coef = c;
      w.out_expo = e;
      w.status   = st;
      w.last     = last;
      want_q.push_back(w);
   endfunction

   function int find_expo(logic signed [15:0] e);
      foreach (expo_tbl[k]) begin
         if (expo_tbl[k] == e) return k;
      end
      return -1;
   endfunction

   // fold one term into the sorted table
   function void fold_term(logic signed [31:0] c, logic signed [15:0] e);
      int     idx;
      longint sum;
      idx = 0;
      if (c == 0) begin
         owe_word('0, '0, stac_pkg::ST_ZERO, 1'b1);
         return;
      end
      while (idx < expo_tbl.size() && expo_tbl[idx] > e) idx++;
      if (idx < expo_tbl.size() && expo_tbl[idx] == e) begin
         sum = longint'(coef_tbl[idx]) + longint'(c);
         if (sum > SUM_HI) sum = SUM_HI;
         if (sum < SUM_LO) sum = SUM_LO;
         if (sum == 0) begin
            coef_tbl.delete(idx);
            expo_tbl.delete(idx);
            owe_word('0, '0, stac_pkg::ST_CANCELLED, 1'b1);
         end else begin
            coef_tbl[idx] = sum[31:0];
            owe_word(sum[31:0], e, stac_pkg::ST_COMBINED, 1'b1);
         end
      end else if (coef_tbl.size() >= depth) begin
         owe_word('0, '0, stac_pkg::ST_FULL, 1'b1);
      end else begin
         coef_tbl.insert(idx, c);
         expo_tbl.insert(idx, e);
         owe_word(c, e, stac_pkg::ST_INSERTED, 1'b1);
      end
   endfunction

   // accepted request word
   function void note_request(stac_pkg::stac_req_type w);
      request_count++;
      case (w.kind)
         stac_pkg::KIND_ADD: fold_term(w.term_coef, w.term_expo);
         stac_pkg::KIND_READ: begin
            if (coef_tbl.size() == 0) begin
               owe_word('0, '0, stac_pkg::ST_EMPTY, 1'b1);
            end else begin
               foreach (coef_tbl[k]) begin
                  owe_word(coef_tbl[k], expo_tbl[k], stac_pkg::ST_TERM,
                           (k == coef_tbl.size() - 1));
               end
            end
         end
         stac_pkg::KIND_CLEAR: begin
            coef_tbl.delete();
            expo_tbl.delete();
         end
         default: ;
      endcase
      if (coef_tbl.size() > peak_terms) peak_terms = coef_tbl.size();
   endfunction

   function void check_field(string name, logic signed [63:0] want,
                             logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: result word %0d field %s: expected %0d, got %0d",
                  $time, result_count, name, want, got);
         bad_count++;
      end
   endfunction

   // accepted result word against the oldest owed word
   function void check_result(stac_pkg::stac_rsp_type got);
      stac_pkg::stac_rsp_type want;
      if (want_q.size() == 0) begin
         $display("%0t: result word with nothing owed: coef %0d expo %0d status %0d last %0d",
                  $time, got.out_coef, got.out_expo, got.status, got.last);
         bad_count++;
         return;
      end
      want = want_q.pop_front();
      result_count++;
      check_field("out_coef", want.out_coef, got.out_coef);
      check_field("out_expo", want.out_expo, got.out_expo);
      check_field("status", want.status, got.status);
      check_field("last", want.last, got.last);
      status_seen[got.status]++;
   endfunction

   function void close_out();
      if (want_q.size() != 0) begin
         $display("%0t: %0d result words never arrived, expected status %0d first",
                  $time, want_q.size(), want_q[0].status);
         bad_count++;
      end
   endfunction
endclass

module sorted_term_accumulator_core_tb;

   localparam int                 TABLE_DEPTH  = 32;
   localparam int                 RANDOM_WORDS = 220;
   localparam int                 STUCK_LIMIT  = 3000;
   localparam int                 DRAIN_CYCLES = 40;
   localparam int                 HOLD_CYCLES  = 160;
   localparam logic [1:0]         KIND_IGNORED = 2'd3;
   localparam logic signed [31:0] COEF_MAX     = 32'sh7fff_ffff;
   localparam logic signed [31:0] COEF_MIN     = 32'sh8000_0000;
   localparam logic signed [15:0] EXPO_MAX     = 16'sh7fff;
   localparam logic signed [15:0] EXPO_MIN     = 16'sh8000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   stac_pkg::stac_req_type req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   stac_pkg::stac_rsp_type rsp_data;

   poly_scoreboard sb;
   int             send_calm;
   int             recv_calm;
   int             hold_span;
   int             word_count;
   int             stuck_cycles;
   int             fills_done;
   bit             burst_done;

   sorted_term_accumulator_core #(.MAX_TERMS(TABLE_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // idle cycles before a word, with runs of back to back words
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 11) == 0) begin
         calm = $urandom_range(4, 24);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   // offer one word at a falling edge and hold it until taken
   task automatic send_word(input stac_pkg::stac_req_type w);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (w.kind != KIND_IGNORED) word_count++;
   endtask

   task automatic send_add(input logic signed [31:0] c, input logic signed [15:0] e);
      stac_pkg::stac_req_type w;
      w.kind      = stac_pkg::KIND_ADD;
      w.term_coef = c;
      w.term_expo = e;
      send_word(w);
   endtask

   // non-add words carry random fields
   task automatic send_kind(input logic [1:0] k);
      stac_pkg::stac_req_type w;
      w.kind      = k;
      w.term_coef = $urandom;
      w.term_expo = 16'($urandom);
      send_word(w);
   endtask

   // stop offering and wait for every owed result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.want_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [15:0] fresh_expo();
      logic signed [15:0] e;
      do e = 16'($urandom); while (sb.find_expo(e) >= 0);
      return e;
   endfunction

   function automatic logic signed [31:0] nonzero_coef();
      logic signed [31:0] c;
      c = $urandom;
      if (c == 0) c = 32'sd1;
      return c;
   endfunction

   // adds mostly over a narrow exponent range so terms combine and cancel, then usually a read
   task automatic run_mixed_sequence();
      int                 n;
      int                 pick;
      int                 idx;
      int                 ci;
      int                 ei;
      logic signed [31:0] c;
      logic signed [15:0] e;
      n = $urandom_range(2, 8);
      repeat (n) begin
         pick = $urandom_range(0, 15);
         ei   = int'($urandom_range(0, 8)) - 4;
         ci   = int'($urandom_range(0, 262143)) - 131072;
         e    = 16'(ei);
         c    = ci;
         if (pick == 0) begin
            c = '0;
         end else if (pick == 1) begin
            c = $urandom;
            e = 16'($urandom);
         end else if (pick == 2) begin
            c = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
         end else if (pick <= 6 && sb.coef_tbl.size() != 0) begin
            idx = $urandom_range(0, sb.coef_tbl.size() - 1);
            e   = sb.expo_tbl[idx];
            c   = -sb.coef_tbl[idx];
         end
         send_add(c, e);
      end
      if ($urandom_range(0, 3) != 0) send_kind(stac_pkg::KIND_READ);
   endtask

   // fill the table, overflow it, combine and cancel while full, then insert, read and clear
   task automatic run_fill_sequence();
      int idx;
      while (sb.coef_tbl.size() < TABLE_DEPTH) send_add(nonzero_coef(), fresh_expo());
      repeat (2) send_add(nonzero_coef(), fresh_expo());
      idx = $urandom_range(0, TABLE_DEPTH - 1);
      send_add(32'sd65536, sb.expo_tbl[idx]);
      idx = $urandom_range(0, sb.coef_tbl.size() - 1);
      send_add(-sb.coef_tbl[idx], sb.expo_tbl[idx]);
      send_add(nonzero_coef(), fresh_expo());
      send_kind(stac_pkg::KIND_READ);
      send_kind(stac_pkg::KIND_CLEAR);
   endtask

   // result side: random stalls, one long hold on request
   initial begin : result_sink
      int gap;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         gap = draw_gap(recv_calm);
         if (hold_span > 0) begin
            gap       = hold_span;
            hold_span = 0;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // monitor both channels and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
         end
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results owed",
                     $time, STUCK_LIMIT, sb.want_q.size());
            $display("sorted_term_accumulator_core: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int r;
      sb           = new(TABLE_DEPTH);
      send_calm    = 0;
      recv_calm    = 0;
      hold_span    = 0;
      word_count   = 0;
      stuck_cycles = 0;
      fills_done   = 0;
      burst_done   = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty read, zero term, saturation both ways, cancel, ignored kind
      send_kind(stac_pkg::KIND_READ);
      send_add('0, 16'sd5);
      send_add(COEF_MAX, EXPO_MAX);
      send_add(32'sd1, EXPO_MAX);
      send_add(COEF_MIN, EXPO_MIN);
      send_add(-32'sd1, EXPO_MIN);
      send_add(32'sd65536, 16'sd0);
      send_add(-32'sd65536, 16'sd0);
      send_add(32'sh0000_8000, -16'sd1);
      send_add(-32'sd5, EXPO_MAX);
      send_kind(stac_pkg::KIND_READ);
      send_kind(KIND_IGNORED);
      send_kind(stac_pkg::KIND_READ);
      send_kind(stac_pkg::KIND_CLEAR);
      send_kind(stac_pkg::KIND_READ);
      send_add(COEF_MIN, 16'sd0);
      send_add(COEF_MIN, 16'sd0);
      send_add(COEF_MAX, 16'sd0);
      send_add(32'sd1, 16'sd0);
      send_kind(stac_pkg::KIND_READ);
      send_kind(stac_pkg::KIND_CLEAR);

      // random: mostly structured add sequences, some fills, some noise
      word_count = 0;
      while (word_count < RANDOM_WORDS) begin
         if (!burst_done && word_count >= 100) begin
            // receiver holds off while words keep coming back to back
            burst_done = 1;
            hold_span  = HOLD_CYCLES;
            send_calm  = 30;
            repeat (28) send_add(nonzero_coef(), 16'($urandom_range(0, 15)));
            drain_results();
            send_kind(stac_pkg::KIND_READ);
         end
         r = $urandom_range(0, 11);
         if (r <= 5) begin
            run_mixed_sequence();
         end else if (r == 6 && fills_done < 2) begin
            fills_done++;
            run_fill_sequence();
         end else if (r <= 8) begin
            send_kind(2'($urandom_range(0, 3)));
            send_add($urandom, 16'($urandom));
         end else if (r == 9) begin
            send_kind(stac_pkg::KIND_CLEAR);
         end else if (r == 10) begin
            drain_results();
            send_kind(stac_pkg::KIND_READ);
         end else begin
            send_kind(stac_pkg::KIND_READ);
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      sb.close_out();

      $display("covered %0d request words, %0d result words, table peak %0d of %0d terms",
               sb.request_count, sb.result_count, sb.peak_terms, TABLE_DEPTH);
      $display("statuses: inserted %0d combined %0d cancelled %0d zero %0d",
               sb.status_seen[stac_pkg::ST_INSERTED], sb.status_seen[stac_pkg::ST_COMBINED],
               sb.status_seen[stac_pkg::ST_CANCELLED], sb.status_seen[stac_pkg::ST_ZERO]);
      $display("statuses: full %0d term %0d empty %0d",
               sb.status_seen[stac_pkg::ST_FULL], sb.status_seen[stac_pkg::ST_TERM],
               sb.status_seen[stac_pkg::ST_EMPTY]);
      if (sb.bad_count == 0) begin
         $display("sorted_term_accumulator_core: match");
      end else begin
         $display("sorted_term_accumulator_core: mismatch");
      end
      $finish;
   end

endmodule

// ----- sorted_term_accumulator_core.f -----
hw/rtl/stac_pkg.sv
hw/rtl/stac_ctrl.sv
hw/rtl/stac_datapath.sv
hw/rtl/sorted_term_accumulator_core.sv
hw/rtl/stac_checker.sv
test/sorted_term_accumulator_core_tb.sv
